FILE: design/u8dec_pkg.sv
// Package for the UTF-8 decoder: field widths, status codes and lead-byte patterns.
package u8dec_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned CpW      = 21;
	localparam int unsigned StatusW  = 2;
	localparam int unsigned HeldW    = 2;
	localparam int unsigned PayloadW = 18;

	// result status codes
	localparam logic [StatusW-1:0] ST_OK      = 2'd0;
	localparam logic [StatusW-1:0] ST_TRUNC   = 2'd1;
	localparam logic [StatusW-1:0] ST_INVALID = 2'd2;
	localparam logic [StatusW-1:0] ST_RANGE   = 2'd3;

	// largest code point that fits in 16 bits
	localparam logic [CpW-1:0] Limit16 = 21'h00FFFF;

	// lead byte prefixes
	localparam logic [2:0] LEAD2_PFX = 3'b110;
	localparam logic [3:0] LEAD3_PFX = 4'b1110;
	localparam logic [4:0] LEAD4_PFX = 5'b11110;

	// one decoded result word
	typedef struct packed {
		logic [CpW-1:0]     code_point;
		logic [StatusW-1:0] status;
	} result_t;

endpackage

FILE: design/utf8_to_ucs2_decoder.sv
// UTF-8 to 16-bit code point decoder: byte decode, sequence state and output buffer.
//
// Input channel: byte_valid/byte_ready carry one text byte (in_byte) with
// end_of_text set on the final byte of the text. Output channel:
// result_valid/result_ready carry one result word (code_point, status).
// A byte that completes a sequence, ends the text mid-sequence or closes an
// illegal four-byte run yields one result; other bytes only update state.
// Each byte is decoded in the cycle it is accepted and its result word is
// registered in the output register, or in the skid register while that is occupied.
// Throughput is one byte per cycle while byte_ready is high, set by the single
// decode stage that updates the held lead byte, byte count and payload bits.
// The output has a two-word buffer (output register plus skid register):
// while the receiver stalls, one more result can be taken in, and
// byte_ready drops only once the skid register is full. Bytes that make
// no result are still accepted then only if the skid is free.
// Reset (arst_n low) clears the sequence state and the valid flags of both buffer entries;
// the block then waits idle for a lead byte.
module utf8_to_ucs2_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  logic [u8dec_pkg::ByteW-1:0]   in_byte,
	input  logic                          end_of_text,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [u8dec_pkg::CpW-1:0]     code_point,
	output logic [u8dec_pkg::StatusW-1:0] status
);

	// sequence state
	logic [u8dec_pkg::HeldW-1:0]    held_q;
	logic [u8dec_pkg::ByteW-1:0]    lead_q;
	logic [u8dec_pkg::PayloadW-1:0] payload_q;

	// output buffer
	u8dec_pkg::result_t out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	// decode results
	logic                           accept, pop, push;
	u8dec_pkg::result_t             res;
	logic [u8dec_pkg::HeldW-1:0]    held_d;
	logic [u8dec_pkg::ByteW-1:0]    lead_d;
	logic [u8dec_pkg::PayloadW-1:0] payload_d;
	logic [2:0]                     pos;
	logic [u8dec_pkg::PayloadW-1:0] acc;
	logic [u8dec_pkg::CpW-1:0]      cp4;

	assign byte_ready = !skid_valid_q;
	assign accept     = byte_valid && byte_ready;
	assign pop        = out_valid_q && result_ready;

	assign pos = {1'b0, held_q} + 3'd1;
	assign acc = {payload_q[u8dec_pkg::PayloadW-7:0], in_byte[5:0]};
	assign cp4 = {lead_q[2:0], acc};

	// byte decode: one step of the sequence
	always_comb begin
		push           = 1'b0;
		res.code_point = '0;
		res.status     = u8dec_pkg::ST_OK;
		held_d         = '0;
		lead_d         = '0;
		payload_d      = '0;
		if (held_q == '0) begin
			if (!in_byte[7]) begin
				push           = 1'b1;
				res.code_point = {14'd0, in_byte[6:0]};
			end else if (end_of_text) begin
				push       = 1'b1;
				res.status = u8dec_pkg::ST_TRUNC;
			end else begin
				held_d = 2'd1;
				lead_d = in_byte;
			end
		end else if (pos == 3'd2 && lead_q[7:5] == u8dec_pkg::LEAD2_PFX) begin
			push           = 1'b1;
			res.code_point = {10'd0, lead_q[4:0], 6'd0} | {3'd0, acc};
		end else if (pos == 3'd3 && lead_q[7:4] == u8dec_pkg::LEAD3_PFX) begin
			push           = 1'b1;
			res.code_point = {5'd0, lead_q[3:0], 12'd0} | {3'd0, acc};
		end else if (pos == 3'd4) begin
			push = 1'b1;
			if (lead_q[7:3] == u8dec_pkg::LEAD4_PFX) begin
				if (cp4 > u8dec_pkg::Limit16) begin
					res.status = u8dec_pkg::ST_RANGE;
				end else begin
					res.code_point = cp4;
				end
			end else begin
				res.status = u8dec_pkg::ST_INVALID;
			end
		end else if (end_of_text) begin
			push       = 1'b1;
			res.status = u8dec_pkg::ST_TRUNC;
		end else begin
			held_d    = pos[u8dec_pkg::HeldW-1:0];
			lead_d    = lead_q;
			payload_d = acc;
		end
	end

	// sequence state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			lead_q    <= '0;
			payload_q <= '0;
		end else if (accept) begin
			held_q    <= held_d;
			lead_q    <= lead_d;
			payload_q <= payload_d;
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= accept && push;
			end else begin
				out_valid_q  <= accept && push;
			end
		end else if (accept && push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q  <= res;
			end
		end else if (accept && push) begin
			skid_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign code_point   = out_q.code_point;
	assign status       = out_q.status;

	// skid entry only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without output word");

	// error results carry a zero code point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != u8dec_pkg::ST_OK) |-> out_q.code_point == '0)
		else $error("nonzero code point on error status");

	// good results fit in 16 bits
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == u8dec_pkg::ST_OK)
			|-> out_q.code_point <= u8dec_pkg::Limit16)
		else $error("ok result above 16 bits");

	// no payload gathered before the first continuation byte
	a_payload_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == 2'd0 || held_q == 2'd1) |-> payload_q == '0)
		else $error("payload bits set with no continuation held");

endmodule
